@@ rtl/gtr_pkg.sv @@
`default_nettype none
package gtr_pkg;

    localparam int DISPLAY_WIDTH  = 160;
    localparam int DISPLAY_HEIGHT = 48;
    localparam int ROW_BYTES      = (DISPLAY_WIDTH + 7) / 8;
    localparam int FB_BYTES       = ROW_BYTES * DISPLAY_HEIGHT;
    localparam int FB_AW          = (FB_BYTES > 1) ? $clog2(FB_BYTES) : 1;
    localparam int ROW_AW         = (DISPLAY_HEIGHT > 1) ? $clog2(DISPLAY_HEIGHT) : 1;
    localparam int CNT_W          = (FB_AW > 4) ? FB_AW + 1 : 5;

    localparam int GLYPH_COLS  = 5;
    localparam int DRAW_BYTES  = 16;
    localparam int CURSOR_W    = 10;
    localparam int ADVANCE     = 6;
    localparam int CURSOR_MAX  = 1023;
    localparam logic [5:0] START_ROW_RESET = 6'd20;

    // item opcodes
    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_DRAW  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // configuration register indexes
    localparam logic REG_START_COLUMN = 1'b0;
    localparam logic REG_START_ROW    = 1'b1;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_DISPATCH,
        ST_CLEAR,
        ST_CLEAR_END,
        ST_READ,
        ST_READ_END,
        ST_LOOKUP,
        ST_DRAW_RD,
        ST_DRAW_RMW,
        ST_DRAW_END,
        ST_NULL_END
    } step_t;

    typedef enum logic [1:0] {
        JMP_NEXT,
        JMP_GOTO,
        JMP_IF,
        JMP_DISPATCH
    } jmp_t;

    typedef enum logic [1:0] {
        COND_NO_START,
        COND_CLR_MORE,
        COND_DRAW_MORE,
        COND_NO_GLYPH
    } cond_t;

    typedef struct packed {
        jmp_t  jmp;
        cond_t cond;
        step_t target;
        logic  cnt_clr;
        logic  cnt_inc;
        logic  zero_wr;
        logic  draw_rd;
        logic  draw_wr;
        logic  byte_rd;
        logic  glyph_ld;
        logic  cursor_ld;
        logic  cursor_adv;
        logic  emit;
        logic  emit_byte;
        logic  emit_found;
    } ctl_t;

    typedef struct packed {
        logic       start;
        logic [1:0] opcode;
        logic       clr_last;
        logic       draw_last;
        logic       glyph_found;
    } stat_t;

    typedef struct packed {
        logic             we;
        logic [FB_AW-1:0] waddr;
        logic [7:0]       wdata;
        logic             re;
        logic [FB_AW-1:0] raddr;
    } ram_req_t;

    typedef struct packed {
        logic                        found;
        logic [GLYPH_COLS-1:0][7:0]  cols;
    } glyph_t;

    function automatic glyph_t mk_glyph(input logic [7:0] c0, input logic [7:0] c1,
                                        input logic [7:0] c2, input logic [7:0] c3,
                                        input logic [7:0] c4);
        glyph_t g;
        g.found   = 1'b1;
        g.cols[0] = c0;
        g.cols[1] = c1;
        g.cols[2] = c2;
        g.cols[3] = c3;
        g.cols[4] = c4;
        return g;
    endfunction

    // Font ROM: lower case folds onto upper case.
    function automatic glyph_t glyph_lookup(input logic [7:0] code);
        logic [7:0] c;
        glyph_t     g;
        c = code;
        if (code >= "a" && code <= "z")
            c = code - 8'd32;
        g = '0;
        case (c)
            "A": g = mk_glyph(8'h7E, 8'h09, 8'h09, 8'h09, 8'h7E);
            "B": g = mk_glyph(8'h7F, 8'h49, 8'h49, 8'h49, 8'h36);
            "C": g = mk_glyph(8'h3E, 8'h41, 8'h41, 8'h41, 8'h22);
            "D": g = mk_glyph(8'h7F, 8'h41, 8'h41, 8'h41, 8'h3E);
            "E": g = mk_glyph(8'h7F, 8'h49, 8'h49, 8'h49, 8'h41);
            "F": g = mk_glyph(8'h7F, 8'h09, 8'h09, 8'h01, 8'h01);
            "G": g = mk_glyph(8'h3E, 8'h41, 8'h49, 8'h49, 8'h3A);
            "H": g = mk_glyph(8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F);
            "I": g = mk_glyph(8'h41, 8'h41, 8'h7F, 8'h41, 8'h41);
            "J": g = mk_glyph(8'h20, 8'h40, 8'h41, 8'h3F, 8'h01);
            "K": g = mk_glyph(8'h7F, 8'h08, 8'h14, 8'h22, 8'h41);
            "L": g = mk_glyph(8'h7F, 8'h40, 8'h40, 8'h40, 8'h40);
            "M": g = mk_glyph(8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F);
            "N": g = mk_glyph(8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F);
            "O": g = mk_glyph(8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E);
            "P": g = mk_glyph(8'h7F, 8'h09, 8'h09, 8'h09, 8'h06);
            "R": g = mk_glyph(8'h7F, 8'h09, 8'h19, 8'h29, 8'h46);
            "S": g = mk_glyph(8'h26, 8'h49, 8'h49, 8'h49, 8'h32);
            "T": g = mk_glyph(8'h01, 8'h01, 8'h7F, 8'h01, 8'h01);
            "U": g = mk_glyph(8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F);
            "W": g = mk_glyph(8'h3F, 8'h40, 8'h38, 8'h40, 8'h3F);
            " ": g = mk_glyph(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
            "0": g = mk_glyph(8'h3E, 8'h45, 8'h49, 8'h51, 8'h3E);
            "1": g = mk_glyph(8'h21, 8'h21, 8'h7F, 8'h01, 8'h01);
            "2": g = mk_glyph(8'h21, 8'h43, 8'h45, 8'h49, 8'h31);
            "3": g = mk_glyph(8'h42, 8'h41, 8'h51, 8'h69, 8'h46);
            "4": g = mk_glyph(8'h0F, 8'h08, 8'h08, 8'h7F, 8'h08);
            default: g = '0;
        endcase
        return g;
    endfunction

endpackage
`default_nettype wire

@@ rtl/gtr_fb_ram.sv @@
`default_nettype none
module gtr_fb_ram #(
    parameter int DEPTH = 960,
    parameter int WIDTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    always_ff @(posedge clk)
    begin
        if (re)
            rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

@@ rtl/gtr_useq.sv @@
`default_nettype none
module gtr_useq (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire gtr_pkg::stat_t stat,
    output gtr_pkg::ctl_t      ctl,
    output logic               busy
);
    import gtr_pkg::*;

    step_t step_reg;
    step_t step_next;
    logic  cond_true;

    // control store: one word per step
    function automatic ctl_t ucode_word(input step_t s);
        ctl_t w;
        w        = '0;
        w.jmp    = JMP_NEXT;
        w.cond   = COND_NO_START;
        w.target = ST_IDLE;
        case (s)
            ST_INIT:
            begin
                w.zero_wr = 1'b1;
                w.cnt_inc = 1'b1;
                w.jmp     = JMP_IF;
                w.cond    = COND_CLR_MORE;
                w.target  = ST_INIT;
            end
            ST_IDLE:
            begin
                w.cnt_clr = 1'b1;
                w.jmp     = JMP_IF;
                w.cond    = COND_NO_START;
                w.target  = ST_IDLE;
            end
            ST_DISPATCH:
            begin
                w.jmp = JMP_DISPATCH;
            end
            ST_CLEAR:
            begin
                w.zero_wr = 1'b1;
                w.cnt_inc = 1'b1;
                w.jmp     = JMP_IF;
                w.cond    = COND_CLR_MORE;
                w.target  = ST_CLEAR;
            end
            ST_CLEAR_END:
            begin
                w.cursor_ld = 1'b1;
                w.emit      = 1'b1;
                w.jmp       = JMP_GOTO;
            end
            ST_READ:
            begin
                w.byte_rd = 1'b1;
            end
            ST_READ_END:
            begin
                w.emit      = 1'b1;
                w.emit_byte = 1'b1;
                w.jmp       = JMP_GOTO;
            end
            ST_LOOKUP:
            begin
                w.glyph_ld = 1'b1;
                w.jmp      = JMP_IF;
                w.cond     = COND_NO_GLYPH;
                w.target   = ST_NULL_END;
            end
            ST_DRAW_RD:
            begin
                w.draw_rd = 1'b1;
                w.cnt_inc = 1'b1;
            end
            ST_DRAW_RMW:
            begin
                w.draw_wr = 1'b1;
                w.draw_rd = 1'b1;
                w.cnt_inc = 1'b1;
                w.jmp     = JMP_IF;
                w.cond    = COND_DRAW_MORE;
                w.target  = ST_DRAW_RMW;
            end
            ST_DRAW_END:
            begin
                w.draw_wr    = 1'b1;
                w.cursor_adv = 1'b1;
                w.emit       = 1'b1;
                w.emit_found = 1'b1;
                w.jmp        = JMP_GOTO;
            end
            ST_NULL_END:
            begin
                w.emit = 1'b1;
                w.jmp  = JMP_GOTO;
            end
            default:
            begin
                w.jmp = JMP_GOTO;
            end
        endcase
        return w;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= ST_INIT;
        else
            step_reg <= step_next;
    end

    always_comb
    begin
        ctl  = ucode_word(step_reg);
        busy = (step_reg != ST_IDLE);

        case (ctl.cond)
            COND_NO_START:  cond_true = !stat.start;
            COND_CLR_MORE:  cond_true = !stat.clr_last;
            COND_DRAW_MORE: cond_true = !stat.draw_last;
            COND_NO_GLYPH:  cond_true = !stat.glyph_found;
            default:        cond_true = 1'b0;
        endcase

        case (ctl.jmp)
            JMP_NEXT:  step_next = step_t'(4'(step_reg + 4'd1));
            JMP_GOTO:  step_next = ctl.target;
            JMP_IF:    step_next = cond_true ? ctl.target : step_t'(4'(step_reg + 4'd1));
            JMP_DISPATCH:
            begin
                case (stat.opcode)
                    OP_CLEAR: step_next = ST_CLEAR;
                    OP_DRAW:  step_next = ST_LOOKUP;
                    OP_READ:  step_next = ST_READ;
                    default:  step_next = ST_NULL_END;
                endcase
            end
            default:   step_next = ST_IDLE;
        endcase
    end

endmodule
`default_nettype wire

@@ rtl/gtr_dpath.sv @@
`default_nettype none
module gtr_dpath (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire gtr_pkg::ctl_t             ctl,
    input  wire logic                      accept,
    input  wire logic [1:0]                opcode,
    input  wire logic [7:0]                char_code,
    input  wire logic [9:0]                read_address,
    input  wire logic [7:0]                start_column,
    input  wire logic [5:0]                start_row,
    input  wire logic [7:0]                ram_rdata,
    output gtr_pkg::ram_req_t              ram_req,
    output gtr_pkg::stat_t                 stat,
    output logic                           done,
    output logic [7:0]                     read_byte,
    output logic                           glyph_found,
    output logic [gtr_pkg::CURSOR_W-1:0]   cursor_column
);
    import gtr_pkg::*;

    logic [1:0]          op_reg;
    logic [7:0]          code_reg;
    logic [9:0]          addr_reg;
    glyph_t              glyph_reg;
    logic [CURSOR_W-1:0] cursor_reg;
    logic [CURSOR_W-1:0] cursor_next;
    logic [CNT_W-1:0]    cnt_reg;
    logic [CNT_W-1:0]    cnt_next;
    logic [FB_AW-1:0]    wr_addr_reg;
    logic [7:0]          wr_mask_reg;
    logic                wr_ok_reg;
    logic                done_reg;
    logic                done_next;
    logic [7:0]          read_byte_reg;
    logic [7:0]          read_byte_next;
    logic                found_reg;
    logic                found_next;

    glyph_t              glyph_lut;
    logic                rd_in_range;
    logic [CURSOR_W:0]   cursor_sum;

    // byte window of the glyph being drawn
    logic [2:0]          bit_row;
    logic                half;
    logic [7:0]          pat8;
    logic [15:0]         win;
    logic [7:0]          byte_pat;
    logic [7:0]          col_mask;
    logic [7:0]          byte_col;
    logic [6:0]          pix_y;
    logic [ROW_AW-1:0]   row_idx;
    logic [FB_AW-1:0]    draw_addr;
    logic                draw_ok;
    logic [10:0]         xpos;

    assign glyph_lut   = glyph_lookup(code_reg);
    assign rd_in_range = (int'(addr_reg) < FB_BYTES);

    always_comb
    begin
        bit_row = cnt_reg[3:1];
        half    = cnt_reg[0];
        pat8    = '0;
        for (int c = 0; c < GLYPH_COLS; c++)
            pat8[7 - c] = glyph_reg.cols[c][bit_row];
        win      = {pat8, 8'h00} >> cursor_reg[2:0];
        byte_pat = half ? win[7:0] : win[15:8];
        byte_col = {1'b0, cursor_reg[CURSOR_W-1:3]} + {7'd0, half};
        pix_y    = {1'b0, start_row} + {4'd0, bit_row};
        col_mask = '0;
        for (int j = 0; j < 8; j++)
        begin
            xpos        = {byte_col, 3'b000} + 11'(7 - j);
            col_mask[j] = (int'(xpos) < DISPLAY_WIDTH);
        end
        row_idx   = ROW_AW'(DISPLAY_HEIGHT - 1) - ROW_AW'(pix_y);
        draw_addr = FB_AW'(row_idx) * FB_AW'(ROW_BYTES) + FB_AW'(byte_col);
        draw_ok   = (int'(pix_y) < DISPLAY_HEIGHT) && (int'(byte_col) < ROW_BYTES);
    end

    always_comb
    begin
        ram_req.we    = 1'b0;
        ram_req.waddr = wr_addr_reg;
        ram_req.wdata = ram_rdata | wr_mask_reg;
        ram_req.re    = 1'b0;
        ram_req.raddr = draw_addr;
        if (ctl.zero_wr)
        begin
            ram_req.we    = 1'b1;
            ram_req.waddr = cnt_reg[FB_AW-1:0];
            ram_req.wdata = 8'h00;
        end
        else if (ctl.draw_wr)
        begin
            ram_req.we = wr_ok_reg;
        end
        if (ctl.byte_rd)
        begin
            ram_req.re    = 1'b1;
            ram_req.raddr = FB_AW'(addr_reg);
        end
        else if (ctl.draw_rd)
        begin
            ram_req.re = 1'b1;
        end
    end

    always_comb
    begin
        cursor_sum  = {1'b0, cursor_reg} + (CURSOR_W + 1)'(ADVANCE);
        cursor_next = cursor_reg;
        if (ctl.cursor_ld)
            cursor_next = CURSOR_W'(start_column);
        else if (ctl.cursor_adv)
            cursor_next = (int'(cursor_sum) > CURSOR_MAX) ? CURSOR_W'(CURSOR_MAX)
                                                          : cursor_sum[CURSOR_W-1:0];

        cnt_next = cnt_reg;
        if (ctl.cnt_clr)
            cnt_next = '0;
        else if (ctl.cnt_inc)
            cnt_next = cnt_reg + 1'b1;

        done_next      = ctl.emit;
        read_byte_next = read_byte_reg;
        found_next     = found_reg;
        if (ctl.emit)
        begin
            read_byte_next = (ctl.emit_byte && rd_in_range) ? ram_rdata : 8'h00;
            found_next     = ctl.emit_found;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg <= '0;
            cnt_reg    <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            cursor_reg <= cursor_next;
            cnt_reg    <= cnt_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= opcode;
            code_reg <= char_code;
            addr_reg <= read_address;
        end
        if (ctl.glyph_ld)
            glyph_reg <= glyph_lut;
        if (ctl.draw_rd)
        begin
            wr_addr_reg <= draw_addr;
            wr_mask_reg <= byte_pat & col_mask;
            wr_ok_reg   <= draw_ok;
        end
        read_byte_reg <= read_byte_next;
        found_reg     <= found_next;
    end

    assign stat.start       = accept;
    assign stat.opcode      = op_reg;
    assign stat.clr_last    = (cnt_reg == CNT_W'(FB_BYTES - 1));
    assign stat.draw_last   = (cnt_reg == CNT_W'(DRAW_BYTES - 1));
    assign stat.glyph_found = glyph_lut.found;

    assign done          = done_reg;
    assign read_byte     = read_byte_reg;
    assign glyph_found   = found_reg;
    assign cursor_column = cursor_reg;

endmodule
`default_nettype wire

@@ rtl/glyph_text_rasterizer.sv @@
// Per item: a drawn character takes 16 read-modify-write bytes, overlapped,
// one byte per cycle; a clear zeroes the framebuffer one byte per cycle.
// Next item accepted in the cycle done is shown.
// Reset: a clearing pass zeroes the framebuffer with busy high;
// configuration writes are taken during it. Results cannot be stalled.
`default_nettype none
module glyph_text_rasterizer (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // item channel
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  opcode,
    input  wire logic [7:0]  char_code,
    input  wire logic [9:0]  read_address,
    // result channel: valid for the single cycle done is high
    output logic             done,
    output logic [7:0]       read_byte,
    output logic             glyph_found,
    output logic [9:0]       cursor_column,
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import gtr_pkg::*;

    logic       accept;
    logic       cfg_wr;
    logic [7:0] start_column_reg;
    logic [7:0] start_column_next;
    logic [5:0] start_row_reg;
    logic [5:0] start_row_next;
    ctl_t       ctl;
    stat_t      stat;
    ram_req_t   ram_req;
    logic [7:0] ram_rdata;

    // an item is taken only while the sequencer waits in its idle step
    assign accept = start && !busy;

    // configuration registers: decode on the word address bit only
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        start_column_next = start_column_reg;
        start_row_next    = start_row_reg;
        if (cfg_wr)
        begin
            case (paddr[2])
                REG_START_COLUMN: start_column_next = pwdata[7:0];
                REG_START_ROW:    start_row_next    = pwdata[5:0];
                default:          start_row_next    = start_row_reg;
            endcase
        end
        case (paddr[2])
            REG_START_COLUMN: prdata = {24'd0, start_column_reg};
            REG_START_ROW:    prdata = {26'd0, start_row_reg};
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_column_reg <= '0;
            start_row_reg    <= START_ROW_RESET;
        end
        else
        begin
            start_column_reg <= start_column_next;
            start_row_reg    <= start_row_next;
        end
    end

    // sequencer: step counter and control store
    gtr_useq u_useq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctl   (ctl),
        .busy  (busy)
    );

    // cursor, counter, glyph window and result registers
    gtr_dpath u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .accept        (accept),
        .opcode        (opcode),
        .char_code     (char_code),
        .read_address  (read_address),
        .start_column  (start_column_reg),
        .start_row     (start_row_reg),
        .ram_rdata     (ram_rdata),
        .ram_req       (ram_req),
        .stat          (stat),
        .done          (done),
        .read_byte     (read_byte),
        .glyph_found   (glyph_found),
        .cursor_column (cursor_column)
    );

    // framebuffer, bottom row first, MSB is the leftmost pixel
    gtr_fb_ram #(
        .DEPTH (FB_BYTES),
        .WIDTH (8),
        .AW    (FB_AW)
    ) u_fb_ram (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .re    (ram_req.re),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

endmodule
`default_nettype wire

@@ rtl/gtr_checker.sv @@
`default_nettype none
module gtr_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic       done,
    input wire logic [7:0] read_byte,
    input wire logic       glyph_found
);

    // every result step is followed by the idle step, so strobes never touch
    a_done_gap: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done strobed in consecutive cycles");

    // a drawn character never carries read data
    a_found_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (done && glyph_found) |-> (read_byte == 8'd0))
        else $error("glyph_found with nonzero read_byte");

    // a taken item holds the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy did not rise after accept");

    // a result comes only out of work in progress
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("done without preceding busy");

endmodule

bind glyph_text_rasterizer gtr_checker u_gtr_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .read_byte   (read_byte),
    .glyph_found (glyph_found)
);
`default_nettype wire

@@ bench/glyph_text_rasterizer_tb.sv @@
`timescale 1ns / 100ps

module glyph_text_rasterizer_tb;
    import gtr_pkg::*;

    // opcode 3 has no name in the package; the block answers it without acting
    localparam logic [1:0] OP_NONE = 2'd3;

    // one result item as the block presents it
    typedef struct packed {
        logic [7:0] rb;
        logic       gf;
        logic [9:0] cur;
    } raster_out_t;

    // one line of the directed table; a register line reuses code as the
    // start column and addr[5:0] as the start row
    typedef struct packed {
        logic        is_cfg;
        logic [1:0]  op;
        logic [7:0]  code;
        logic [9:0]  addr;
        logic        typed;
        raster_out_t want;
    } text_row_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  opcode;
    logic [7:0]  char_code;
    logic [9:0]  read_address;
    logic        done;
    logic [7:0]  read_byte;
    logic        glyph_found;
    logic [9:0]  cursor_column;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    glyph_text_rasterizer DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .opcode        (opcode),
        .char_code     (char_code),
        .read_address  (read_address),
        .done          (done),
        .read_byte     (read_byte),
        .glyph_found   (glyph_found),
        .cursor_column (cursor_column),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Shadow copy of the framebuffer, pen position and registers.
    logic [7:0]  shadow_fb [0:FB_BYTES-1];
    int          pen_x;
    logic [7:0]  shadow_col;
    logic [5:0]  shadow_row;

    raster_out_t expected_out [$];
    raster_out_t mon_want;
    text_row_t   text_rows [$];
    int          err_count;

    // Font: {found, column 0 .. column 4}, column 0 in the top byte.
    // Fold lower case onto upper case before the lookup.
    function automatic logic [40:0] font_bits(input logic [7:0] code);
        logic [7:0] c;
        c = (code >= "a" && code <= "z") ? code - 8'd32 : code;
        case (c)
            "A": return {1'b1, 40'h7E_09_09_09_7E};
            "B": return {1'b1, 40'h7F_49_49_49_36};
            "C": return {1'b1, 40'h3E_41_41_41_22};
            "D": return {1'b1, 40'h7F_41_41_41_3E};
            "E": return {1'b1, 40'h7F_49_49_49_41};
            "F": return {1'b1, 40'h7F_09_09_01_01};
            "G": return {1'b1, 40'h3E_41_49_49_3A};
            "H": return {1'b1, 40'h7F_08_08_08_7F};
            "I": return {1'b1, 40'h41_41_7F_41_41};
            "J": return {1'b1, 40'h20_40_41_3F_01};
            "K": return {1'b1, 40'h7F_08_14_22_41};
            "L": return {1'b1, 40'h7F_40_40_40_40};
            "M": return {1'b1, 40'h7F_02_0C_02_7F};
            "N": return {1'b1, 40'h7F_04_08_10_7F};
            "O": return {1'b1, 40'h3E_41_41_41_3E};
            "P": return {1'b1, 40'h7F_09_09_09_06};
            "R": return {1'b1, 40'h7F_09_19_29_46};
            "S": return {1'b1, 40'h26_49_49_49_32};
            "T": return {1'b1, 40'h01_01_7F_01_01};
            "U": return {1'b1, 40'h3F_40_40_40_3F};
            "W": return {1'b1, 40'h3F_40_38_40_3F};
            " ": return {1'b1, 40'h00_00_00_00_00};
            "0": return {1'b1, 40'h3E_45_49_51_3E};
            "1": return {1'b1, 40'h21_21_7F_01_01};
            "2": return {1'b1, 40'h21_43_45_49_31};
            "3": return {1'b1, 40'h42_41_51_69_46};
            "4": return {1'b1, 40'h0F_08_08_7F_08};
            default: return '0;
        endcase
    endfunction

    // Apply one accepted item to the shadow state and return what the block
    // should answer.
    function automatic raster_out_t rasterize_item(input logic [1:0] op,
                                                   input logic [7:0] code,
                                                   input logic [9:0] addr);
        raster_out_t r;
        logic [40:0] g;
        logic [7:0]  col;
        int          x;
        int          y;
        int          idx;
        r = '0;
        case (op)
            OP_CLEAR:
            begin
                for (idx = 0; idx < FB_BYTES; idx++)
                    shadow_fb[idx] = 8'h00;
                pen_x = int'(shadow_col);
            end
            OP_DRAW:
            begin
                g = font_bits(code);
                if (g[40])
                begin
                    r.gf = 1'b1;
                    for (int c = 0; c < GLYPH_COLS; c++)
                    begin
                        col = g[39 - 8*c -: 8];
                        for (int b = 0; b < 8; b++)
                        begin
                            x = pen_x + c;
                            y = shadow_row + b;
                            // drop pixels that land off the display
                            if (col[b] && x < DISPLAY_WIDTH && y < DISPLAY_HEIGHT)
                            begin
                                idx = (DISPLAY_HEIGHT - 1 - y) * ROW_BYTES + x / 8;
                                shadow_fb[idx] = shadow_fb[idx] | (8'h80 >> (x % 8));
                            end
                        end
                    end
                    pen_x = (pen_x + ADVANCE > CURSOR_MAX) ? CURSOR_MAX : pen_x + ADVANCE;
                end
            end
            OP_READ:
            begin
                if (addr < FB_BYTES)
                    r.rb = shadow_fb[addr];
            end
            default: ;
        endcase
        r.cur = pen_x[9:0];
        return r;
    endfunction

    function automatic text_row_t mk_row(input logic is_cfg, input logic [1:0] op,
                                         input logic [7:0] code, input logic [9:0] addr,
                                         input logic typed, input logic [7:0] rb,
                                         input logic gf, input logic [9:0] cur);
        text_row_t t;
        t.is_cfg   = is_cfg;
        t.op       = op;
        t.code     = code;
        t.addr     = addr;
        t.typed    = typed;
        t.want.rb  = rb;
        t.want.gf  = gf;
        t.want.cur = cur;
        return t;
    endfunction

    // Pick a character; most of the time one that has a glyph.
    function automatic logic [7:0] pick_char(input int found_pct);
        logic [7:0]  c;
        logic [40:0] g;
        c = 8'($urandom_range(255));
        if ($urandom_range(99) < found_pct)
        begin
            g = font_bits(c);
            while (!g[40])
            begin
                c = 8'($urandom_range(255));
                g = font_bits(c);
            end
        end
        return c;
    endfunction

    // Pick a read address; half of them aim at the rows the text lands on, where those rows lie on the display.
    function automatic logic [9:0] pick_addr();
        int y;
        y = shadow_row + $urandom_range(7);
        if ($urandom_range(1) && y < DISPLAY_HEIGHT)
            return 10'((DISPLAY_HEIGHT - 1 - y) * ROW_BYTES + $urandom_range(ROW_BYTES - 1));
        return 10'($urandom_range(1023));
    endfunction

    // Present one item and hold it until the block takes it. Start stays
    // high afterwards so that back-to-back items need no dead cycle.
    task automatic send_item(input logic [1:0] op, input logic [7:0] code,
                             input logic [9:0] addr, input logic typed,
                             input raster_out_t typed_want);
        raster_out_t r;
        start        <= 1'b1;
        opcode       <= op;
        char_code    <= code;
        read_address <= addr;
        do
            @(posedge clk);
        while (busy);
        r = rasterize_item(op, code, addr);
        expected_out.push_back(typed ? typed_want : r);
    endtask

    // Drop start and hold off; n sets how long.
    task automatic idle_for(input int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Drop start and wait until every expected result has come back.
    task automatic wait_drain();
        start <= 1'b0;
        do
            @(posedge clk);
        while (expected_out.size() != 0);
    endtask

    // Setup cycle, then access cycle; the register takes the value at the
    // edge that closes the access cycle.
    task automatic apb_write(input logic [2:0] a, input logic [31:0] d);
        wait_drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= a;
        pwdata  <= d;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (a[2] == REG_START_ROW)
            shadow_row = d[5:0];
        else
            shadow_col = d[7:0];
    endtask

    // Write both registers; upper data bits carry noise the block must drop.
    task automatic set_layout(input logic [7:0] col, input logic [5:0] row);
        apb_write({REG_START_COLUMN, 2'b00}, {24'($urandom_range(16777215)), col});
        apb_write({REG_START_ROW, 2'b00}, {26'($urandom_range(67108863)), row});
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #40_000_000;
        $display("glyph_text_rasterizer_tb: done, errors");
        $finish;
    end

    // Check every result strobe against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_out.size() == 0)
            begin
                $display("%0t: unexpected result rb=%h gf=%b cur=%0d", $time,
                         read_byte, glyph_found, cursor_column);
                err_count++;
            end
            else
            begin
                mon_want = expected_out.pop_front();
                if (read_byte !== mon_want.rb)
                begin
                    $display("%0t: read_byte expected %h actual %h", $time,
                             mon_want.rb, read_byte);
                    err_count++;
                end
                if (glyph_found !== mon_want.gf)
                begin
                    $display("%0t: glyph_found expected %b actual %b", $time,
                             mon_want.gf, glyph_found);
                    err_count++;
                end
                if (cursor_column !== mon_want.cur)
                begin
                    $display("%0t: cursor_column expected %0d actual %0d", $time,
                             mon_want.cur, cursor_column);
                    err_count++;
                end
            end
        end
    end

    initial
    begin
        int clear_pct;
        int draw_pct;
        int read_pct;
        int idle_pct;
        int found_pct;
        int len;
        int pick;
        logic [1:0] op;
        logic [7:0] code;
        logic [9:0] addr;

        err_count    = 0;
        rst_n        = 1'b0;
        start        = 1'b0;
        opcode       = OP_CLEAR;
        char_code    = 8'h00;
        read_address = 10'd0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = 3'd0;
        pwdata       = 32'd0;

        // shadow state matches the block after reset
        for (int i = 0; i < FB_BYTES; i++)
            shadow_fb[i] = 8'h00;
        pen_x      = 0;
        shadow_col = 8'd0;
        shadow_row = START_ROW_RESET;

        // Directed table. Reset layout: start column 0, start row 20.
        // Out-of-range reads and opcode 3 give zeros right after reset.
        text_rows.push_back(mk_row(1'b0, OP_READ,  8'h00, 10'd0,    1'b1, 8'h00, 1'b0, 10'd0));
        text_rows.push_back(mk_row(1'b0, OP_NONE,  8'hFF, 10'd1023, 1'b1, 8'h00, 1'b0, 10'd0));
        text_rows.push_back(mk_row(1'b0, OP_READ,  8'h00, 10'd1023, 1'b1, 8'h00, 1'b0, 10'd0));
        text_rows.push_back(mk_row(1'b0, OP_READ,  8'h00, 10'd960,  1'b1, 8'h00, 1'b0, 10'd0));
        // a glyph and its lower-case fold each advance 6 columns
        text_rows.push_back(mk_row(1'b0, OP_DRAW,  "A",   10'd0,    1'b1, 8'h00, 1'b1, 10'd6));
        text_rows.push_back(mk_row(1'b0, OP_DRAW,  "a",   10'd0,    1'b1, 8'h00, 1'b1, 10'd12));
        // codes with no glyph leave the cursor in place
        text_rows.push_back(mk_row(1'b0, OP_DRAW,  8'h00, 10'd0,    1'b1, 8'h00, 1'b0, 10'd12));
        text_rows.push_back(mk_row(1'b0, OP_DRAW,  8'hFF, 10'd0,    1'b1, 8'h00, 1'b0, 10'd12));
        text_rows.push_back(mk_row(1'b0, OP_DRAW,  "Q",   10'd0,    1'b1, 8'h00, 1'b0, 10'd12));
        text_rows.push_back(mk_row(1'b0, OP_DRAW,  "z",   10'd0,    1'b1, 8'h00, 1'b0, 10'd12));
        text_rows.push_back(mk_row(1'b0, OP_DRAW,  " ",   10'd0,    1'b1, 8'h00, 1'b1, 10'd18));
        // read back the drawn rows
        text_rows.push_back(mk_row(1'b0, OP_READ,  8'h00, 10'd520,  1'b0, 8'h00, 1'b0, 10'd0));
        text_rows.push_back(mk_row(1'b0, OP_READ,  8'h00, 10'd521,  1'b0, 8'h00, 1'b0, 10'd0));
        text_rows.push_back(mk_row(1'b0, OP_READ,  8'h00, 10'd440,  1'b0, 8'h00, 1'b0, 10'd0));
        text_rows.push_back(mk_row(1'b0, OP_DRAW,  "1",   10'd0,    1'b0, 8'h00, 1'b0, 10'd0));
        text_rows.push_back(mk_row(1'b0, OP_READ,  8'h00, 10'd959,  1'b0, 8'h00, 1'b0, 10'd0));
        text_rows.push_back(mk_row(1'b0, OP_CLEAR, 8'h00, 10'd0,    1'b1, 8'h00, 1'b0, 10'd0));
        text_rows.push_back(mk_row(1'b0, OP_READ,  8'h00, 10'd520,  1'b1, 8'h00, 1'b0, 10'd0));
        // right and bottom edge: glyphs clip against both
        text_rows.push_back(mk_row(1'b1, OP_NONE,  8'd159, 10'd47,  1'b0, 8'h00, 1'b0, 10'd0));
        text_rows.push_back(mk_row(1'b0, OP_CLEAR, 8'h00, 10'd0,    1'b1, 8'h00, 1'b0, 10'd159));
        text_rows.push_back(mk_row(1'b0, OP_DRAW,  "W",   10'd0,    1'b1, 8'h00, 1'b1, 10'd165));
        text_rows.push_back(mk_row(1'b0, OP_READ,  8'h00, 10'd19,   1'b0, 8'h00, 1'b0, 10'd0));
        text_rows.push_back(mk_row(1'b0, OP_DRAW,  "M",   10'd0,    1'b1, 8'h00, 1'b1, 10'd171));
        // register values past the display; the write alone leaves the cursor
        text_rows.push_back(mk_row(1'b1, OP_NONE,  8'd255, 10'd63,  1'b0, 8'h00, 1'b0, 10'd0));
        text_rows.push_back(mk_row(1'b0, OP_NONE,  8'h5A, 10'd512,  1'b1, 8'h00, 1'b0, 10'd171));
        text_rows.push_back(mk_row(1'b0, OP_CLEAR, 8'h00, 10'd0,    1'b1, 8'h00, 1'b0, 10'd255));
        text_rows.push_back(mk_row(1'b0, OP_DRAW,  "H",   10'd0,    1'b1, 8'h00, 1'b1, 10'd261));
        text_rows.push_back(mk_row(1'b0, OP_READ,  8'h00, 10'd19,   1'b0, 8'h00, 1'b0, 10'd0));

        // hold reset, then release on a clock edge
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // walk the directed table back to back
        foreach (text_rows[i])
        begin
            if (text_rows[i].is_cfg)
                set_layout(text_rows[i].code, text_rows[i].addr[5:0]);
            else
                send_item(text_rows[i].op, text_rows[i].code, text_rows[i].addr,
                          text_rows[i].typed, text_rows[i].want);
        end

        // Random phases, each with its own layout, mix and sender idling.
        // Phase 2 has no clears after its opening one and draws mostly real glyphs
        // so that the cursor runs into saturation.
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    set_layout(8'($urandom_range(159)), 6'($urandom_range(47)));
                    clear_pct = 4; draw_pct = 60; read_pct = 33;
                    idle_pct = 0; found_pct = 80; len = 120;
                end
                1:
                begin
                    set_layout(8'd0, 6'd0);
                    clear_pct = 4; draw_pct = 55; read_pct = 38;
                    idle_pct = 76; found_pct = 80; len = 120;
                end
                2:
                begin
                    set_layout(8'd255, 6'd44);
                    clear_pct = 0; draw_pct = 90; read_pct = 9;
                    idle_pct = 0; found_pct = 95; len = 180;
                end
                default:
                begin
                    set_layout(8'($urandom_range(255)), 6'($urandom_range(63)));
                    clear_pct = 3; draw_pct = 60; read_pct = 34;
                    idle_pct = 7; found_pct = 75; len = 120;
                end
            endcase

            // open each phase with a clear so the new start column is loaded
            send_item(OP_CLEAR, 8'($urandom_range(255)), 10'($urandom_range(1023)),
                      1'b0, '0);

            for (int i = 0; i < len; i++)
            begin
                if ($urandom_range(99) < idle_pct)
                    idle_for($urandom_range(1, 24));
                // let the block run dry once before carrying on
                if (ph == 1 && i == 60)
                    wait_drain();

                pick = $urandom_range(99);
                code = 8'($urandom_range(255));
                addr = 10'($urandom_range(1023));
                if (pick < clear_pct)
                    op = OP_CLEAR;
                else if (pick < clear_pct + draw_pct)
                begin
                    op   = OP_DRAW;
                    code = pick_char(found_pct);
                end
                else if (pick < clear_pct + draw_pct + read_pct)
                begin
                    op   = OP_READ;
                    addr = pick_addr();
                end
                else
                    op = OP_NONE;
                send_item(op, code, addr, 1'b0, '0);
            end
        end

        // drain, then watch a little longer for stray strobes
        wait_drain();
        repeat (40) @(posedge clk);
        if (err_count == 0)
            $display("glyph_text_rasterizer_tb: done, clean");
        else
            $display("glyph_text_rasterizer_tb: done, errors");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/gtr_pkg.sv
rtl/gtr_fb_ram.sv
rtl/gtr_useq.sv
rtl/gtr_dpath.sv
rtl/glyph_text_rasterizer.sv
rtl/gtr_checker.sv
bench/glyph_text_rasterizer_tb.sv
